### hw/rtl/salc_pkg.sv
package salc_pkg;

	// Field widths of the access and result channels
	localparam int ADDR_W = 64;
	localparam int BCNT_W = 13;
	localparam int OUT_W  = 11;

	// Line number after dropping at least two offset bits
	localparam int LINE_W = 62;
	// Stored tag width: one bit above any real tag, so all ones marks an empty way
	localparam int TAG_W  = 63;
	// Internal line and miss counters
	localparam int CNT_W  = 13;

	localparam logic [BCNT_W-1:0] MAX_ACCESS_BYTES = 13'd4096;

	localparam logic [3:0] LINE_LOG2_MIN = 4'd2;
	localparam logic [3:0] LINE_LOG2_MAX = 4'd8;

	// Reset values of the geometry registers
	localparam logic [3:0] LINE_LOG2_RST = 4'd6;
	localparam logic [3:0] SETS_LOG2_RST = 4'd6;
	localparam logic [1:0] WAYS_LOG2_RST = 2'd2;

	typedef struct packed {
		logic [3:0] line_log2;
		logic [3:0] sets_log2;
		logic [1:0] ways_log2;
	} cfg_t;

endpackage

### hw/rtl/salc_front.sv
module salc_front #(
	parameter int MAX_SET_BITS = 10,
	parameter int SET_AW       = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  salc_pkg::cfg_t                  cfg,
	input  logic                            enable,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [salc_pkg::ADDR_W-1:0]     byte_address,
	input  logic [salc_pkg::BCNT_W-1:0]     byte_count,
	output logic                            q_valid,
	input  logic                            q_ready,
	output logic [SET_AW-1:0]               q_set,
	output logic [salc_pkg::LINE_W-1:0]     q_tag,
	output logic                            q_last,
	output logic [salc_pkg::CNT_W-1:0]      q_lines
);

	logic                            busy_q;
	logic [salc_pkg::CNT_W-1:0]      remain_q;
	logic [salc_pkg::CNT_W-1:0]      lines_q;
	logic [salc_pkg::LINE_W-1:0]     line_q;
	logic [salc_pkg::LINE_W-1:0]     mask_q;

	logic [3:0]                      lb;
	logic [4:0]                      sb;
	logic [salc_pkg::BCNT_W-1:0]     cnt_eff;
	logic [7:0]                      offset;
	logic [13:0]                     span;
	logic [13:0]                     span_sh;
	logic [salc_pkg::CNT_W-1:0]      lines;
	logic [salc_pkg::ADDR_W-1:0]     addr_sh;
	logic [salc_pkg::LINE_W-1:0]     line_mask;
	logic [SET_AW-1:0]               set_mask;
	logic                            accept;
	logic                            push;

	always_comb begin
		if (cfg.line_log2 < salc_pkg::LINE_LOG2_MIN) begin
			lb = salc_pkg::LINE_LOG2_MIN;
		end else if (cfg.line_log2 > salc_pkg::LINE_LOG2_MAX) begin
			lb = salc_pkg::LINE_LOG2_MAX;
		end else begin
			lb = cfg.line_log2;
		end

		if ({1'b0, cfg.sets_log2} > 5'(MAX_SET_BITS)) begin
			sb = 5'(MAX_SET_BITS);
		end else begin
			sb = {1'b0, cfg.sets_log2};
		end

		if (byte_count == '0) begin
			cnt_eff = salc_pkg::BCNT_W'(1);
		end else if (byte_count > salc_pkg::MAX_ACCESS_BYTES) begin
			cnt_eff = salc_pkg::MAX_ACCESS_BYTES;
		end else begin
			cnt_eff = byte_count;
		end
	end

	assign offset    = byte_address[7:0] & ~(8'hFF << lb);
	assign span      = {6'b0, offset} + {1'b0, cnt_eff} - 14'd1;
	assign span_sh   = span >> lb;
	assign lines     = span_sh[salc_pkg::CNT_W-1:0] + salc_pkg::CNT_W'(1);
	assign addr_sh   = byte_address >> lb;
	assign line_mask = {salc_pkg::LINE_W{1'b1}} >> (lb - salc_pkg::LINE_LOG2_MIN);

	always_comb begin
		for (int i = 0; i < SET_AW; i++) begin
			set_mask[i] = (5'(i) < sb);
		end
	end

	assign in_ready = enable & ~busy_q;
	assign accept   = in_valid & in_ready;
	assign q_valid  = busy_q;
	assign push     = busy_q & q_ready;

	assign q_set   = line_q[SET_AW-1:0] & set_mask;
	assign q_tag   = line_q >> sb;
	assign q_last  = (remain_q == salc_pkg::CNT_W'(1));
	assign q_lines = lines_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			remain_q <= '0;
		end else if (accept) begin
			busy_q   <= 1'b1;
			remain_q <= lines;
		end else if (push) begin
			remain_q <= remain_q - salc_pkg::CNT_W'(1);
			if (q_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Step the line number, wrapping at the top of the address space
	always_ff @(posedge clk) begin
		if (accept) begin
			line_q  <= addr_sh[salc_pkg::LINE_W-1:0];
			mask_q  <= line_mask;
			lines_q <= lines;
		end else if (push) begin
			line_q <= (line_q + salc_pkg::LINE_W'(1)) & mask_q;
		end
	end

endmodule

### hw/rtl/salc_queue.sv
module salc_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   fill_q;
	logic         push;
	logic         pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hw/rtl/salc_back.sv
module salc_back #(
	parameter int SET_AW   = 10,
	parameter int NUM_WAYS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  salc_pkg::cfg_t                  cfg,
	output logic                            clear_done,
	input  logic                            q_valid,
	output logic                            q_ready,
	input  logic [SET_AW-1:0]               q_set,
	input  logic [salc_pkg::LINE_W-1:0]     q_tag,
	input  logic                            q_last,
	input  logic [salc_pkg::CNT_W-1:0]      q_lines,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [salc_pkg::OUT_W-1:0]      miss_count,
	output logic [salc_pkg::OUT_W-1:0]      lines_touched
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_LOOK  = 2'd1;
	localparam logic [1:0] ST_UPD   = 2'd2;

	typedef logic [NUM_WAYS-1:0][salc_pkg::TAG_W-1:0] row_t;

	row_t                            mem [2**SET_AW];

	logic [1:0]                      state_q;
	logic [SET_AW-1:0]               clr_q;
	logic [salc_pkg::CNT_W-1:0]      miss_q;
	logic                            out_valid_q;
	logic [salc_pkg::OUT_W-1:0]      miss_count_q;
	logic [salc_pkg::OUT_W-1:0]      lines_touched_q;
	row_t                            rd_row_q;
	logic [SET_AW-1:0]               set_s1;
	logic [salc_pkg::TAG_W-1:0]      tag_s1;
	logic                            last_s1;
	logic [salc_pkg::CNT_W-1:0]      lines_s1;

	logic [3:0]                      req_ways;
	logic [3:0]                      wcnt;
	logic [3:0]                      hidx;
	logic [3:0]                      lim;
	logic                            any_hit;
	row_t                            new_row;
	logic                            pop;
	logic                            finish_ok;
	logic                            upd_go;
	logic                            clearing;
	logic [salc_pkg::CNT_W-1:0]      miss_sum;
	logic                            wr_en;
	logic [SET_AW-1:0]               wr_addr;
	row_t                            wr_row;

	assign clearing   = (state_q == ST_CLEAR);
	assign clear_done = ~clearing;
	assign q_ready    = (state_q == ST_LOOK);
	assign pop        = q_valid & q_ready;

	assign req_ways = 4'd1 << cfg.ways_log2;
	assign wcnt     = (req_ways > 4'(NUM_WAYS)) ? 4'(NUM_WAYS) : req_ways;

	// Lowest matching way among those in use wins
	always_comb begin
		any_hit = 1'b0;
		hidx    = 4'd0;
		for (int i = NUM_WAYS - 1; i >= 0; i--) begin
			if ((4'(i) < wcnt) && (rd_row_q[i] == tag_s1)) begin
				any_hit = 1'b1;
				hidx    = 4'(i);
			end
		end
	end

	// Shift the ways in front of the hit (or all in use on a miss) back by one
	assign lim = any_hit ? hidx : (wcnt - 4'd1);

	always_comb begin
		new_row[0] = tag_s1;
		for (int j = 1; j < NUM_WAYS; j++) begin
			new_row[j] = (4'(j) <= lim) ? rd_row_q[j-1] : rd_row_q[j];
		end
	end

	assign finish_ok = ~last_s1 | ~out_valid_q | out_ready;
	assign upd_go    = (state_q == ST_UPD) & finish_ok;
	assign miss_sum  = miss_q + (any_hit ? salc_pkg::CNT_W'(0) : salc_pkg::CNT_W'(1));

	assign wr_en   = clearing | upd_go;
	assign wr_addr = clearing ? clr_q : set_s1;
	assign wr_row  = clearing ? {(NUM_WAYS*salc_pkg::TAG_W){1'b1}} : new_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			miss_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SET_AW'(1);
					if (clr_q == {SET_AW{1'b1}}) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (pop) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (finish_ok) begin
						state_q <= ST_LOOK;
						if (last_s1) begin
							miss_q      <= '0;
							out_valid_q <= 1'b1;
						end else begin
							miss_q <= miss_sum;
						end
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go && last_s1) begin
			miss_count_q    <= miss_sum[salc_pkg::OUT_W-1:0];
			lines_touched_q <= lines_s1[salc_pkg::OUT_W-1:0];
		end
	end

	// Capture the line being worked on
	always_ff @(posedge clk) begin
		if (pop) begin
			set_s1   <= q_set;
			tag_s1   <= {1'b0, q_tag};
			last_s1  <= q_last;
			lines_s1 <= q_lines;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (pop) begin
			rd_row_q <= mem[q_set];
		end
	end

	assign out_valid     = out_valid_q;
	assign miss_count    = miss_count_q;
	assign lines_touched = lines_touched_q;

endmodule

### hw/rtl/set_assoc_lru_cache_model.sv
// Throughput: a touched line takes a read of the set row from the single-port set store,
// then a compare of the ways and a write-back of the reordered row; on the last line of an
// access the write-back waits until the output register is free for the new result.
// Reset: clears control state, loads the geometry defaults, then sweeps the tag store to all
// ones, one set per cycle across all 2**SET_AW sets (at least 2), with in_ready held low.
module set_assoc_lru_cache_model #(
	parameter int MAX_SET_BITS = 10,
	parameter int MAX_WAYS     = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [3:0]                      cfg_data,

	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [salc_pkg::ADDR_W-1:0]     byte_address,
	input  logic [salc_pkg::BCNT_W-1:0]     byte_count,
	input  logic                            write_access,

	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [salc_pkg::OUT_W-1:0]      miss_count,
	output logic [salc_pkg::OUT_W-1:0]      lines_touched
);

	// Keep at least one set address bit so the store always has a row to index
	localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	// Ways actually used: a power of two no larger than the way limit, at most eight
	localparam int NUM_WAYS = (MAX_WAYS >= 8) ? 8 : (MAX_WAYS >= 4) ? 4 :
	                          (MAX_WAYS >= 2) ? 2 : 1;
	localparam int QW       = SET_AW + salc_pkg::LINE_W + 1 + salc_pkg::CNT_W;

	localparam logic [1:0] REG_LINE_BYTES_LOG2 = 2'd0;
	localparam logic [1:0] REG_SETS_LOG2       = 2'd1;
	localparam logic [1:0] REG_WAYS_LOG2       = 2'd2;

	salc_pkg::cfg_t                  cfg_q;
	logic                            clear_done;

	logic                            fq_valid;
	logic                            fq_ready;
	logic [SET_AW-1:0]               fq_set;
	logic [salc_pkg::LINE_W-1:0]     fq_tag;
	logic                            fq_last;
	logic [salc_pkg::CNT_W-1:0]      fq_lines;

	logic                            bq_valid;
	logic                            bq_ready;
	logic [QW-1:0]                   bq_data;

	// Geometry registers: the user must write them only while idle; the block itself does not
	// enforce this and takes every transfer at once. An index past the last register is accepted and dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_log2 <= salc_pkg::LINE_LOG2_RST;
			cfg_q.sets_log2 <= salc_pkg::SETS_LOG2_RST;
			cfg_q.ways_log2 <= salc_pkg::WAYS_LOG2_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LINE_BYTES_LOG2: cfg_q.line_log2 <= cfg_data;
				REG_SETS_LOG2:       cfg_q.sets_log2 <= cfg_data;
				REG_WAYS_LOG2:       cfg_q.ways_log2 <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// Front: transfer an access in, split it into lines and hand out one
	// set/tag lookup per cycle while the queue has room. write_access does
	// not steer anything: a write looks up like a read.
	salc_front #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.SET_AW       (SET_AW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.enable       (clear_done),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_address (byte_address),
		.byte_count   (byte_count),
		.q_valid      (fq_valid),
		.q_ready      (fq_ready),
		.q_set        (fq_set),
		.q_tag        (fq_tag),
		.q_last       (fq_last),
		.q_lines      (fq_lines)
	);

	// Two-entry queue of line lookups decouples splitting from the set updates
	salc_queue #(
		.W (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  ({fq_set, fq_tag, fq_last, fq_lines}),
		.pop_valid  (bq_valid),
		.pop_ready  (bq_ready),
		.pop_data   (bq_data)
	);

	// Back: read the set, search its ways, write back in LRU order, count misses,
	// and hold the per-access result in an output register until it transfers.
	salc_back #(
		.SET_AW   (SET_AW),
		.NUM_WAYS (NUM_WAYS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.clear_done    (clear_done),
		.q_valid       (bq_valid),
		.q_ready       (bq_ready),
		.q_set         (bq_data[QW-1 -: SET_AW]),
		.q_tag         (bq_data[salc_pkg::CNT_W+1 +: salc_pkg::LINE_W]),
		.q_last        (bq_data[salc_pkg::CNT_W]),
		.q_lines       (bq_data[salc_pkg::CNT_W-1:0]),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.miss_count    (miss_count),
		.lines_touched (lines_touched)
	);

endmodule
